/* src/b32e_pkg.sv */
// b32e_pkg: shared types, constants and the symbol lookup for the base32 encoder
// no dependencies; imported by every module of the block
`default_nettype none
package b32e_pkg;

	localparam int unsigned GROUP_BYTES = 5;
	localparam int unsigned GROUP_W     = 8 * GROUP_BYTES;
	localparam int unsigned SLICE_W     = 5;
	localparam int unsigned CHARS       = 8;
	localparam int unsigned QDEPTH      = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef logic [2:0] pos_t;
	typedef logic [3:0] nsym_t;

	typedef struct packed {
		logic [GROUP_W-1:0] bits;
		nsym_t              nsym;
		logic               fin;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] sym_char(input logic [SLICE_W-1:0] idx);
		logic [7:0] ch;
		begin
			if (idx < 5'd26) begin
				ch = 8'h41 + {3'b000, idx};
			end else begin
				ch = 8'h32 + {3'b000, idx - 5'd26};
			end
			return ch;
		end
	endfunction

	function automatic nsym_t sym_count(input logic [2:0] nbytes);
		nsym_t n;
		begin
			case (nbytes)
				3'd1:    n = 4'd2;
				3'd2:    n = 4'd4;
				3'd3:    n = 4'd5;
				3'd4:    n = 4'd7;
				default: n = 4'd8;
			endcase
			return n;
		end
	endfunction

endpackage
`default_nettype wire

/* src/b32e_front.sv */
// b32e_front: takes message bytes and builds left-aligned 40-bit groups
// depends on b32e_pkg; hands closed groups to b32e_queue
`default_nettype none
module b32e_front import b32e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire q_status_t  q_status,
	output logic            push,
	output group_t          push_group
);

	logic [GROUP_W-1:0] group_q;
	logic [2:0]         count_q;
	logic [2:0]         count_nx;
	logic [GROUP_W-1:0] group_nx;
	logic               take;
	logic               close;

	assign in_ready = !q_status.full;
	assign take     = in_valid && in_ready;
	assign count_nx = count_q + 3'd1;
	assign close    = (count_nx == 3'(GROUP_BYTES)) || final_byte;

	always_comb begin
		group_nx = group_q;
		case (count_q)
			3'd0:    group_nx[39:32] = data_byte;
			3'd1:    group_nx[31:24] = data_byte;
			3'd2:    group_nx[23:16] = data_byte;
			3'd3:    group_nx[15:8]  = data_byte;
			default: group_nx[7:0]   = data_byte;
		endcase
	end

	assign push            = take && close;
	assign push_group.bits = group_nx;
	assign push_group.nsym = sym_count(count_nx);
	assign push_group.fin  = final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (close) begin
				group_q <= '0;
				count_q <= '0;
			end else begin
				group_q <= group_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule
`default_nettype wire

/* src/b32e_queue.sv */
// b32e_queue: two-entry group queue between the byte front and character back
// depends on b32e_pkg
`default_nettype none
module b32e_queue import b32e_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire group_t push_group,
	input  wire logic   pop,
	output group_t      head,
	output q_status_t   status
);

	group_t     slot_q [QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign head         = slot_q[rd_q];
	assign status.full  = (fill_q == 2'(QDEPTH));
	assign status.empty = (fill_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/b32e_back.sv */
// b32e_back: walks the head group and sends eight characters, one per cycle while out_ready is high
// depends on b32e_pkg; reads groups from b32e_queue
`default_nettype none
module b32e_back import b32e_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire group_t    head,
	input  wire q_status_t q_status,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     out_char,
	output logic           group_last,
	output logic           message_last
);

	pos_t               pos_q;
	logic               advance;
	logic               load;
	logic [GROUP_W-1:0] shifted;
	logic [7:0]         ch;
	logic               at_end;

	assign advance = !out_valid || out_ready;
	assign load    = advance && !q_status.empty;
	assign at_end  = (pos_q == pos_t'(CHARS - 1));
	assign pop     = load && at_end;
	assign shifted = head.bits << (6'(pos_q) * 6'd5);

	always_comb begin
		if ({1'b0, pos_q} < head.nsym) begin
			ch = sym_char(shifted[GROUP_W-1 -: SLICE_W]);
		end else begin
			ch = PAD_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
			if (load) begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char     <= ch;
			group_last   <= at_end;
			message_last <= at_end && head.fin;
		end
	end

endmodule
`default_nettype wire

/* src/base32_stream_encoder_unit.sv */
// base32_stream_encoder_unit: top level of the streaming base32 encoder
// depends on b32e_pkg, b32e_front, b32e_queue and b32e_back
`default_nettype none
// Bytes enter one per cycle while the queue is not full and collect into
// 40-bit groups; a group closes on its fifth byte or on a byte flagged final,
// and then yields eight characters (alphabet symbols, '=' padding for a short
// final group), one per cycle from an output register while out_ready is
// high, with group_last on the eighth and message_last also set when the
// group was closed by the final byte. A two-group queue sits between the byte
// side and the character side, so bytes keep flowing while characters wait.
// Sustained throughput is set by the character side: eight characters per
// group, a short final group included. When idle, it takes a closing byte's
// group from the queue and registers the first character into out_char.
module base32_stream_encoder_unit import b32e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            group_last,
	output logic            message_last
);

	q_status_t q_status;
	logic      push;
	group_t    push_group;
	logic      pop;
	group_t    head;

	b32e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	b32e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	b32e_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.group_last   (group_last),
		.message_last (message_last)
	);

`ifndef SYNTHESIS
	a_msg_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_last |-> group_last)
		else $error("message end without group end");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && !(push && q_status.full))
		else $error("queue status inconsistent or push while full");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_char >= 8'h41 && out_char <= 8'h5A) ||
			(out_char >= 8'h32 && out_char <= 8'h37) || out_char == PAD_CHAR))
		else $error("illegal output character");
`endif

endmodule
`default_nettype wire
